[src/kms_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package kms_pkg;

	// Width and reset value of the num_sources register.
	localparam int               CFG_W                 = 4;
	localparam logic [CFG_W-1:0] CFG_NUM_SOURCES_RESET = 4'd8;

	// Per-source status of the head register.
	typedef enum logic [1:0] {
		ST_WAITING = 2'd0,
		ST_READY   = 2'd1,
		ST_ENDED   = 2'd2
	} kms_status_t;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_CHECK = 4'b0010,
		S_SCAN  = 4'b0100,
		S_EMIT  = 4'b1000
	} kms_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic in_ready;
		logic scan_start;
		logic scan_step;
		logic emit;
	} kms_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic in_fire;
		logic done_sent;
		logic any_waiting;
		logic scan_last;
		logic out_free;
	} kms_stat_t;

endpackage

`default_nettype wire

[src/kms_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface kms_in_if #(
	parameter int SRC_W       = 3,
	parameter int VALUE_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic        [SRC_W-1:0]       source;
	logic signed [VALUE_WIDTH-1:0] value;
	logic                          end_of_source;

	modport src (output valid, source, value, end_of_source, input ready);
	modport snk (input valid, source, value, end_of_source, output ready);
	modport mon (input valid, ready, source, value, end_of_source);
endinterface

`default_nettype wire

[src/kms_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface kms_out_if #(
	parameter int SRC_W       = 3,
	parameter int VALUE_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] merged_value;
	logic        [SRC_W-1:0]       refill_source;
	logic                          all_done;

	modport src (output valid, merged_value, refill_source, all_done, input ready);
	modport snk (input valid, merged_value, refill_source, all_done, output ready);
	modport mon (input valid, ready, merged_value, refill_source, all_done);
endinterface

`default_nettype wire

[src/kms_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module kms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output      logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

`default_nettype wire

[src/kms_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module kms_ctrl import kms_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire kms_stat_t stat,
	output      kms_cmd_t  cmd
);
	kms_state_t state_q;
	kms_state_t state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (stat.in_fire) begin
					state_nxt = S_CHECK;
				end
			end
			S_CHECK: begin
				// No result while a live source still owes its next value, nor after the done result.
				if (stat.done_sent || stat.any_waiting) begin
					state_nxt = S_IDLE;
				end else begin
					cmd.scan_start = 1'b1;
					state_nxt      = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.scan_last) begin
					state_nxt = S_EMIT;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end
endmodule

`default_nettype wire

[src/kms_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module kms_dp import kms_pkg::*; #(
	parameter int NUM_SOURCES = 8,
	parameter int VALUE_WIDTH = 32,
	localparam int SRC_W      = $clog2(NUM_SOURCES),
	localparam int CNT_W      = $clog2(NUM_SOURCES + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [CFG_W-1:0] cfg_wr_data,
	input  wire kms_cmd_t         cmd,
	output      kms_stat_t        stat,
	kms_in_if.snk                 items,
	kms_out_if.src                results
);
	logic [CFG_W-1:0]       num_sources_q;
	logic [CNT_W-1:0]       n_eff;
	kms_status_t            status_q [NUM_SOURCES];
	logic                   done_sent_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   rd_vld_s1;
	logic [SRC_W-1:0]       rd_idx_s1;
	logic [VALUE_WIDTH-1:0] rd_data;
	logic                   found_q;
	logic [SRC_W-1:0]       best_idx_q;
	logic [VALUE_WIDTH-1:0] best_val_q;
	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] out_value_q;
	logic [SRC_W-1:0]       out_src_q;
	logic                   out_done_q;
	logic                   in_fire;
	logic                   src_ok;
	logic                   take;
	logic                   any_waiting;
	logic                   cmp_hit;

	assign n_eff = (int'(num_sources_q) > NUM_SOURCES) ? CNT_W'(NUM_SOURCES)
		: CNT_W'(num_sources_q);

	assign in_fire = cmd.in_ready & items.valid;
	assign src_ok  = CNT_W'(items.source) < n_eff;
	// Only a live source that is waiting takes the item; everything else drops it.
	assign take    = in_fire & ~done_sent_q & src_ok
		& (status_q[items.source] == ST_WAITING);

	always_comb begin
		any_waiting = 1'b0;
		for (int k = 0; k < NUM_SOURCES; k++) begin
			if ((CNT_W'(k) < n_eff) && (status_q[k] == ST_WAITING)) begin
				any_waiting = 1'b1;
			end
		end
	end

	kms_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (NUM_SOURCES)
	) u_head_ram (
		.clk   (clk),
		.we    (take & ~items.end_of_source),
		.waddr (items.source),
		.wdata (items.value),
		.re    (cmd.scan_step),
		.raddr (cnt_q[SRC_W-1:0]),
		.rdata (rd_data)
	);

	// Strict less-than while scanning upward keeps ties on the lowest index.
	assign cmp_hit = rd_vld_s1 && (status_q[rd_idx_s1] == ST_READY)
		&& (!found_q || ($signed(rd_data) < $signed(best_val_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_sources_q <= CFG_NUM_SOURCES_RESET;
			done_sent_q   <= 1'b0;
			cnt_q         <= '0;
			rd_vld_s1     <= 1'b0;
			found_q       <= 1'b0;
			out_valid_q   <= 1'b0;
			for (int k = 0; k < NUM_SOURCES; k++) begin
				status_q[k] <= ST_WAITING;
			end
		end else begin
			if (cfg_wr_en) begin
				num_sources_q <= cfg_wr_data;
			end
			if (take) begin
				status_q[items.source] <= items.end_of_source ? ST_ENDED : ST_READY;
			end
			if (cmd.scan_start) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
			end else if (cmd.scan_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			rd_vld_s1 <= cmd.scan_step;
			if (cmp_hit) begin
				found_q <= 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				if (found_q) begin
					status_q[best_idx_q] <= ST_WAITING;
				end else begin
					done_sent_q <= 1'b1;
				end
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q[SRC_W-1:0];
		if (cmp_hit) begin
			best_idx_q <= rd_idx_s1;
			best_val_q <= rd_data;
		end
		if (cmd.emit) begin
			out_value_q <= found_q ? best_val_q : '0;
			out_src_q   <= found_q ? best_idx_q : '0;
			out_done_q  <= ~found_q;
		end
	end

	assign items.ready           = cmd.in_ready;
	assign results.valid         = out_valid_q;
	assign results.merged_value  = out_value_q;
	assign results.refill_source = out_src_q;
	assign results.all_done      = out_done_q;

	assign stat.in_fire     = in_fire;
	assign stat.done_sent   = done_sent_q;
	assign stat.any_waiting = any_waiting;
	assign stat.scan_last   = (cnt_q == n_eff);
	assign stat.out_free    = ~out_valid_q | results.ready;
endmodule

`default_nettype wire

[src/kway_merge_select_unit.sv]
// Channel   Dir  Payload                                    Transfer when
// items     in   source, value, end_of_source               valid && ready
// results   out  merged_value, refill_source, all_done      valid && ready
// cfg       in   cfg_wr_data (num_sources)                  cfg_wr_en
//
// One item at a time: accept, status check, a scan of the head RAM that reads
// one source per cycle, then the result load; an item that yields no result
// goes from the status check straight back to accept.
// The scan length is set by the single read port of the head RAM.
// Reset clears all source states to waiting and restores num_sources.
// A result waits in the output register; a second one holds the emit state.
`timescale 1ns / 1ps
`default_nettype none

module kway_merge_select_unit import kms_pkg::*; #(
	parameter int NUM_SOURCES = 8,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [CFG_W-1:0] cfg_wr_data,
	kms_in_if.snk                 items,
	kms_out_if.src                results
);
	kms_cmd_t  cmd;
	kms_stat_t stat;

	kms_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	kms_dp #(
		.NUM_SOURCES (NUM_SOURCES),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.stat        (stat),
		.items       (items),
		.results     (results)
	);
endmodule

`default_nettype wire

[src/kms_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module kms_checker #(
	parameter int VALUE_WIDTH = 32,
	parameter int SRC_W       = 3
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_ready,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic [VALUE_WIDTH-1:0] merged_value,
	input wire logic [SRC_W-1:0]       refill_source,
	input wire logic                   all_done
);
	logic done_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_seen_q <= 1'b0;
		end else if (out_valid && out_ready && all_done) begin
			done_seen_q <= 1'b1;
		end
	end

	// Nothing follows the done result until reset.
	a_nothing_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		!(done_seen_q && out_valid))
		else $error("result offered after the done result");

	// Items are handled one at a time.
	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after a transfer");

	// A new result is loaded only while the input side is closed.
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while the input side was idle");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
		&& $stable(merged_value) && $stable(refill_source)
		&& $stable(all_done))
		else $error("stalled result changed");

	a_done_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && all_done |->
		merged_value == '0 && refill_source == '0)
		else $error("done result carries a value");
endmodule

bind kway_merge_select_unit kms_checker #(
	.VALUE_WIDTH (VALUE_WIDTH),
	.SRC_W       ($clog2(NUM_SOURCES))
) u_kms_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (items.valid),
	.in_ready      (items.ready),
	.out_valid     (results.valid),
	.out_ready     (results.ready),
	.merged_value  (results.merged_value),
	.refill_source (results.refill_source),
	.all_done      (results.all_done)
);

`default_nettype wire

[sim/kway_merge_select_unit_tb.sv]
`timescale 1ns / 1ps

module kway_merge_select_unit_tb;
	import kms_pkg::*;

	localparam int SRCS        = 8;
	localparam int VW          = 32;
	localparam int IDLE_TAIL   = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 600000;
	localparam int MAX_REPORTS = 40;
	localparam int PHASES      = 6;

	localparam logic signed [VW-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VW-1:0] VAL_MAX = 32'sh7fff_ffff;

	localparam int PHASE_CFG   [PHASES] = '{8, 1, 5, 15, 3, 8};
	localparam int PHASE_TX    [PHASES] = '{1, 0, 0, 1, 1, 0};
	localparam int PHASE_RX    [PHASES] = '{1, 1, 1, 1, 0, 0};
	localparam int PHASE_ITEMS [PHASES] = '{250, 120, 200, 200, 150, 300};

	typedef struct packed {
		logic [VW-1:0] merged_value;
		logic [2:0]    refill_source;
		logic          all_done;
	} merge_result_t;

	// Tracks the head and status of every stream and queues the merge output
	// that each accepted item is due to produce.
	class merge_tracker;
		kms_status_t          status [SRCS];
		logic signed [VW-1:0] heads [SRCS];
		bit                   done_seen;
		logic [3:0]           num_cfg;
		int                   errors;
		merge_result_t        awaited [$];

		function new();
			foreach (status[k]) begin
				status[k] = ST_WAITING;
				heads[k]  = '0;
			end
			done_seen = 1'b0;
			num_cfg   = 4'd8;
			errors    = 0;
		endfunction

		function int active();
			return (int'(num_cfg) > SRCS) ? SRCS : int'(num_cfg);
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void note_item(logic [2:0] src, logic signed [VW-1:0] val, logic eos);
			int            n;
			int            best;
			bit            any;
			merge_result_t r;
			n    = active();
			best = 0;
			any  = 1'b0;
			if (done_seen)
				return;
			if (int'(src) < n && status[src] == ST_WAITING) begin
				if (eos) begin
					status[src] = ST_ENDED;
				end else begin
					heads[src]  = val;
					status[src] = ST_READY;
				end
			end
			for (int k = 0; k < n; k++) begin
				if (status[k] == ST_WAITING)
					return;
				if (status[k] == ST_READY) begin
					if (!any || heads[k] < heads[best])
						best = k;
					any = 1'b1;
				end
			end
			r = '0;
			if (any) begin
				status[best]    = ST_WAITING;
				r.merged_value  = heads[best];
				r.refill_source = 3'(best);
			end else begin
				done_seen  = 1'b1;
				r.all_done = 1'b1;
			end
			awaited.push_back(r);
		endfunction

		function void mismatch(string field, logic signed [63:0] e, logic signed [63:0] g);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch: expected %0d, got %0d", $time, field, e, g);
		endfunction

		function void check_result(logic signed [VW-1:0] mv, logic [2:0] rs, logic ad);
			merge_result_t e;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected result: expected none, got value %0d source %0d done %0b",
						$time, mv, rs, ad);
				return;
			end
			e = awaited.pop_front();
			if (mv !== e.merged_value)
				mismatch("merged_value", $signed(e.merged_value), mv);
			if (rs !== e.refill_source)
				mismatch("refill_source", {61'd0, e.refill_source}, {61'd0, rs});
			if (ad !== e.all_done)
				mismatch("all_done", {63'd0, e.all_done}, {63'd0, ad});
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [3:0] cfg_wr_data;

	kms_in_if  #(.SRC_W(3), .VALUE_WIDTH(VW)) items_if ();
	kms_out_if #(.SRC_W(3), .VALUE_WIDTH(VW)) results_if ();

	kway_merge_select_unit #(
		.NUM_SOURCES(SRCS),
		.VALUE_WIDTH(VW)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.items      (items_if),
		.results    (results_if)
	);

	merge_tracker         tracker;
	int                   tx_mode;
	int                   rx_mode;
	bit                   hold_req;
	longint               cycle_count = 0;
	logic signed [VW-1:0] last_val [SRCS];

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic int sender_gap();
		int r;
		r = $urandom_range(0, 99);
		if (tx_mode == 0 || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int stall_length();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(15, 50);
	endfunction

	// Source 0 never ends and at most four others do, so the merge stays
	// alive under every setting until the final phase.
	function automatic bit may_end(logic [2:0] src);
		int ended;
		ended = 0;
		for (int k = 1; k < SRCS; k++)
			if (tracker.status[k] == ST_ENDED)
				ended++;
		return (src != 3'd0) && (ended < 4);
	endfunction

	function automatic logic signed [VW-1:0] stream_value(logic [2:0] src);
		longint nxt;
		int     k;
		k = $urandom_range(0, SRCS - 1);
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: begin
				case ($urandom_range(0, 3))
					0: return VAL_MIN;
					1: return VAL_MAX;
					2: return '0;
					default: return -1;
				endcase
			end
			2: return last_val[src];
			// A tie with another stream's head.
			3: return (tracker.status[k] == ST_READY) ? tracker.heads[k] : last_val[src];
			default: begin
				nxt = longint'(last_val[src]) + $urandom_range(0, 2000);
				if (nxt > longint'(VAL_MAX))
					nxt = longint'(VAL_MIN) + $urandom_range(0, 1000);
				return nxt[VW-1:0];
			end
		endcase
	endfunction

	// Holds the item until its transfer, then either leaves valid high for the
	// next call or idles for a random gap.
	task automatic send_item(input logic [2:0] src, input logic signed [VW-1:0] val,
			input logic eos);
		int gap;
		items_if.valid         <= 1'b1;
		items_if.source        <= src;
		items_if.value         <= val;
		items_if.end_of_source <= eos;
		do
			@(posedge clk);
		while (!(items_if.valid === 1'b1 && items_if.ready === 1'b1));
		tracker.note_item(src, val, eos);
		gap = sender_gap();
		if (gap > 0) begin
			items_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain(input int tail);
		items_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (tracker.pending() != 0);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [3:0] v);
		drain(IDLE_TAIL);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.num_cfg = v;
	endtask

	task automatic next_random_item(output bit counted);
		int                   open_srcs [$];
		int                   n;
		logic [2:0]           src;
		logic signed [VW-1:0] val;
		logic                 eos;
		n = tracker.active();
		for (int k = 0; k < n; k++)
			if (tracker.status[k] == ST_WAITING)
				open_srcs.push_back(k);
		// Mostly refill a stream that is waiting; the rest is noise that the
		// block should drop.
		if (open_srcs.size() > 0 && $urandom_range(0, 99) < 88)
			src = 3'(open_srcs[$urandom_range(0, open_srcs.size() - 1)]);
		else
			src = 3'($urandom_range(0, SRCS - 1));
		counted = (int'(src) < n) && (tracker.status[src] == ST_WAITING);
		val = stream_value(src);
		if (counted)
			eos = may_end(src) && ($urandom_range(0, 119) == 0);
		else
			eos = 1'($urandom_range(0, 1));
		send_item(src, val, eos);
		if (counted && !eos)
			last_val[src] = val;
	endtask

	task automatic run_random(input int n_items);
		int cnt;
		bit paused;
		bit counted;
		cnt    = 0;
		paused = 1'b0;
		while (cnt < n_items) begin
			if (!paused && cnt >= n_items / 2) begin
				drain(0);
				paused = 1'b1;
			end
			next_random_item(counted);
			if (counted)
				cnt++;
		end
	endtask

	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		results_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (results_if.valid === 1'b1 && results_if.ready === 1'b1)
				tracker.check_result(results_if.merged_value, results_if.refill_source,
					results_if.all_done);
			if (stall_left > 0) begin
				stall_left--;
				results_if.ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HOLD_CYCLES - 1;
				results_if.ready <= 1'b0;
			end else if (rx_mode != 0 && $urandom_range(0, 99) < 25) begin
				stall_left = stall_length() - 1;
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= 1'b1;
			end
		end
	end

	initial begin
		tracker = new();
		arst_n                 <= 1'b0;
		cfg_wr_en              <= 1'b0;
		cfg_wr_data            <= '0;
		items_if.valid         <= 1'b0;
		items_if.source        <= '0;
		items_if.value         <= '0;
		items_if.end_of_source <= 1'b0;
		tx_mode  = 1;
		rx_mode  = 1;
		hold_req = 1'b0;
		foreach (last_val[k])
			last_val[k] = $signed($urandom) >>> 3;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_cfg(4'd8);
		// Fill streams 0 to 6 with the value extremes and a tie on the minimum, and end stream 7.
		send_item(3'd0, VAL_MIN, 1'b0);
		send_item(3'd1, VAL_MAX, 1'b0);
		send_item(3'd2, 32'sd0, 1'b0);
		send_item(3'd3, -32'sd1, 1'b0);
		send_item(3'd4, VAL_MIN, 1'b0);
		send_item(3'd5, 32'sd1, 1'b0);
		send_item(3'd6, 32'sh5555_5555, 1'b0);
		send_item(3'd7, 32'shAAAA_AAAA, 1'b1);
		// Items for a ready stream and for an ended stream are dropped.
		send_item(3'd1, 32'sd5, 1'b0);
		send_item(3'd7, 32'sd3, 1'b0);
		send_item(3'd0, VAL_MIN, 1'b0);
		send_item(3'd0, VAL_MAX, 1'b0);
		send_item(3'd4, -32'sd2, 1'b0);
		send_item(3'd4, 32'sd0, 1'b1);

		// A count above the number of streams saturates.
		write_cfg(4'd15);
		send_item(3'd3, VAL_MAX, 1'b0);
		send_item(3'd2, VAL_MAX, 1'b0);

		// With two streams the others are out of play; the first item below
		// is dropped yet still lets the block emit.
		write_cfg(4'd2);
		send_item(3'd6, 32'sd0, 1'b0);
		send_item(3'd5, 32'sd7, 1'b0);
		send_item(3'd0, -32'sd5, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			write_cfg(4'(PHASE_CFG[p]));
			tx_mode = PHASE_TX[p];
			rx_mode = PHASE_RX[p];
			// The sender keeps offering while the receiver holds off.
			if (p == 2)
				hold_req = 1'b1;
			run_random(PHASE_ITEMS[p]);
		end

		// No streams in use: the next item brings the done result, and the
		// block stays silent after that.
		write_cfg(4'd0);
		tx_mode = 1;
		rx_mode = 0;
		repeat (4)
			send_item(3'($urandom_range(0, SRCS - 1)), $urandom, 1'($urandom_range(0, 1)));
		drain(IDLE_TAIL);

		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[sim.f]
src/kms_pkg.sv
src/kms_in_if.sv
src/kms_out_if.sv
src/kms_ram.sv
src/kms_ctrl.sv
src/kms_dp.sv
src/kway_merge_select_unit.sv
src/kms_checker.sv
sim/kway_merge_select_unit_tb.sv
